// File: rtl/core/prc_pkg.sv
// prc_pkg: field widths, limits and sequencer state codes for the prime range core
// no dependencies; imported by prime_range_count_sum_core, prc_checker and prime_range_count_sum_core_test
package prc_pkg;

    localparam int unsigned BOUND_W = 16;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned SUM_W   = 28;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CAND  = 6'b000010,
        ST_TEST  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_DONE  = 6'b100000
    } prc_state_t;

endpackage

// File: rtl/core/prime_range_count_sum_core.sv
// prime_range_count_sum_core: counts and sums the primes of an inclusive range
// trial division through one shared shift-subtract remainder unit; uses prc_pkg
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_lower_bound[15:0], s_upper_bound[15:0]
//  m_      | out       | m_valid / m_ready  | m_prime_count[12:0], m_prime_sum[27:0]
//
// one request is taken at a time; s_ready is high only while the sequencer is idle
// each trial divisor takes one square compare, B remainder steps (B = bound width,
// 16 by default) and one zero check; each candidate adds one range check, and each
// prime one more compare
// aresetn clears the sequencer and m_valid; a result waiting on m_ready holds the
// sequencer at its end, while an accepted request's scan is never stalled by m_
module prime_range_count_sum_core
    import prc_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BOUND_W-1:0] s_lower_bound,
    input  logic [BOUND_W-1:0] s_upper_bound,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_prime_count,
    output logic [SUM_W-1:0]   m_prime_sum
);

    localparam int unsigned B      = (VALUE_BITS < BOUND_W) ? VALUE_BITS : BOUND_W;
    localparam int unsigned CAND_W = B + 1;
    localparam int unsigned DIV_W  = B / 2 + 2;
    localparam int unsigned SQ_W   = B + 2;
    localparam int unsigned IDX_W  = $clog2(B);

    prc_state_t          state_reg, state_next;
    logic [CAND_W-1:0]   cand_reg, cand_next;
    logic [B-1:0]        hi_reg, hi_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;
    logic [SUM_W-1:0]    m_sum_reg, m_sum_next;

    logic [B-1:0]        lo_masked;
    logic [B-1:0]        cand_low;
    logic [DIV_W:0]      rem_shift;
    logic [SUM_W:0]      sum_add;

    assign lo_masked = s_lower_bound[B-1:0];
    assign cand_low  = cand_reg[B-1:0];
    assign rem_shift = {rem_reg, cand_low[idx_reg]};
    assign sum_add   = {1'b0, sum_reg} + (SUM_W+1)'(cand_reg);

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_prime_count = m_count_reg;
    assign m_prime_sum   = m_sum_reg;

    always_comb begin
        state_next   = state_reg;
        cand_next    = cand_reg;
        hi_next      = hi_reg;
        div_next     = div_reg;
        sq_next      = sq_reg;
        rem_next     = rem_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        m_count_next = m_count_reg;
        m_sum_next   = m_sum_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // raise lower bounds below two to two
                    if (lo_masked < B'(2)) begin
                        cand_next = CAND_W'(2);
                    end else begin
                        cand_next = {1'b0, lo_masked};
                    end
                    hi_next    = s_upper_bound[B-1:0];
                    count_next = '0;
                    sum_next   = '0;
                    state_next = ST_CAND;
                end
            end
            ST_CAND: begin
                if (cand_reg > {1'b0, hi_reg}) begin
                    state_next = ST_DONE;
                end else begin
                    div_next   = DIV_W'(2);
                    sq_next    = SQ_W'(4);
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (sq_reg > SQ_W'(cand_reg)) begin
                    // no divisor up to the square root: prime
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (sum_add[SUM_W]) begin
                        sum_next = SUM_MAX;
                    end else begin
                        sum_next = sum_add[SUM_W-1:0];
                    end
                    cand_next  = cand_reg + CAND_W'(1);
                    state_next = ST_CAND;
                end else begin
                    rem_next   = '0;
                    idx_next   = IDX_W'(B - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_shift >= {1'b0, div_reg}) begin
                    rem_next = DIV_W'(rem_shift - {1'b0, div_reg});
                end else begin
                    rem_next = rem_shift[DIV_W-1:0];
                end
                if (idx_reg == '0) begin
                    state_next = ST_CHECK;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_CHECK: begin
                if (rem_reg == '0) begin
                    cand_next  = cand_reg + CAND_W'(1);
                    state_next = ST_CAND;
                end else begin
                    // (d+1)^2 = d^2 + 2d + 1
                    div_next   = div_reg + DIV_W'(1);
                    sq_next    = sq_reg + SQ_W'({div_reg, 1'b1});
                    state_next = ST_TEST;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_count_next = count_reg;
                    m_sum_next   = sum_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg    <= cand_next;
        hi_reg      <= hi_next;
        div_reg     <= div_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        idx_reg     <= idx_next;
        count_reg   <= count_next;
        sum_reg     <= sum_next;
        m_count_reg <= m_count_next;
        m_sum_reg   <= m_sum_next;
    end

endmodule

// File: rtl/core/prc_checker.sv
// prc_checker: port-level assertions for prime_range_count_sum_core
// uses prc_pkg; bound to prime_range_count_sum_core at the end of this file
module prc_checker
    import prc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [COUNT_W-1:0] m_prime_count,
    input logic [SUM_W-1:0]   m_prime_sum
);

    // a transaction on s_ starts a scan, so the next cycle is busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready high right after an input transaction");

    // results only appear at the end of a scan
    a_result_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised while the core was idle");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_prime_count) && $stable(m_prime_sum)))
        else $error("pending result dropped or changed");

    a_zero_count_zero_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_prime_count == '0) |-> (m_prime_sum == '0))
        else $error("nonzero sum with zero count");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

endmodule

bind prime_range_count_sum_core prc_checker u_prc_checker (.*);

// File: sim/prime_range_count_sum_core_test.sv
`timescale 1ns / 1ps
// prime_range_count_sum_core_test: self-checking bench for the prime range count/sum core
// drives bound pairs, takes count and sum typed in or predicts them by trial division, compares each result
// depends on prc_pkg and prime_range_count_sum_core
module prime_range_count_sum_core_test;
    import prc_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 100;
    localparam int unsigned WATCHDOG_LIMIT = 500000;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned N_ROWS         = 22;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
    } prime_tally_t;

    typedef struct packed {
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        logic               known;
        prime_tally_t       tally;
    } bounds_row_t;

    // known = 1: tally typed in, otherwise predicted
    localparam bounds_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{16'd0,     16'd0,     1'b1, '{13'd0,  28'd0}},
        '{16'd1,     16'd1,     1'b1, '{13'd0,  28'd0}},
        '{16'd0,     16'd1,     1'b1, '{13'd0,  28'd0}},
        '{16'd2,     16'd2,     1'b1, '{13'd1,  28'd2}},
        '{16'd0,     16'd2,     1'b1, '{13'd1,  28'd2}},
        '{16'd3,     16'd3,     1'b1, '{13'd1,  28'd3}},
        '{16'd4,     16'd4,     1'b1, '{13'd0,  28'd0}},
        '{16'd25,    16'd25,    1'b1, '{13'd0,  28'd0}},
        '{16'd49,    16'd49,    1'b1, '{13'd0,  28'd0}},
        '{16'd97,    16'd97,    1'b1, '{13'd1,  28'd97}},
        '{16'd65535, 16'd65535, 1'b1, '{13'd0,  28'd0}},
        '{16'd65535, 16'd0,     1'b1, '{13'd0,  28'd0}},
        '{16'd65535, 16'd65534, 1'b1, '{13'd0,  28'd0}},
        '{16'd10,    16'd5,     1'b1, '{13'd0,  28'd0}},
        '{16'd32768, 16'd32768, 1'b1, '{13'd0,  28'd0}},
        '{16'd0,     16'd10,    1'b0, '{13'd0,  28'd0}},
        '{16'd0,     16'd100,   1'b0, '{13'd0,  28'd0}},
        '{16'd120,   16'd130,   1'b0, '{13'd0,  28'd0}},
        '{16'd1,     16'd1000,  1'b0, '{13'd0,  28'd0}},
        '{16'd65500, 16'd65535, 1'b0, '{13'd0,  28'd0}},
        '{16'd32749, 16'd32771, 1'b0, '{13'd0,  28'd0}},
        '{16'd255,   16'd289,   1'b0, '{13'd0,  28'd0}}
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [BOUND_W-1:0] s_lower_bound = '0;
    logic [BOUND_W-1:0] s_upper_bound = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [COUNT_W-1:0] m_prime_count;
    logic [SUM_W-1:0]   m_prime_sum;

    logic         idle_on = 1'b1;
    int unsigned  error_count = 0;
    prime_tally_t pending_tallies [$];

    prime_range_count_sum_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_lower_bound (s_lower_bound),
        .s_upper_bound (s_upper_bound),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_count (m_prime_count),
        .m_prime_sum   (m_prime_sum)
    );

    always #10 aclk = ~aclk;

    function automatic prime_tally_t tally_primes(input logic [BOUND_W-1:0] lo_in,
                                                  input logic [BOUND_W-1:0] hi_in);
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     cand;
        int unsigned     div;
        int unsigned     count;
        longint unsigned sum;
        logic            is_prime;
        prime_tally_t    tally;
        lo = lo_in;
        hi = hi_in;
        count = 0;
        sum = 0;
        // 0 and 1 are never counted
        if (lo < 2) begin
            lo = 2;
        end
        for (cand = lo; cand <= hi; cand++) begin
            is_prime = 1'b1;
            for (div = 2; div * div <= cand; div++) begin
                if (cand % div == 0) begin
                    is_prime = 1'b0;
                    break;
                end
            end
            if (is_prime) begin
                if (count < COUNT_MAX) begin
                    count++;
                end
                sum += cand;
                if (sum > SUM_MAX) begin
                    sum = SUM_MAX;
                end
            end
        end
        tally.count = count[COUNT_W-1:0];
        tally.sum   = sum[SUM_W-1:0];
        return tally;
    endfunction

    task automatic send_bounds(input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi,
                               input logic known, input prime_tally_t typed);
        prime_tally_t want;
        want = known ? typed : tally_primes(lo, hi);
        if (idle_on && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_lower_bound <= lo;
        s_upper_bound <= hi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_tallies.push_back(want);
    endtask

    always @(posedge aclk) begin
        m_ready <= !(idle_on && $urandom_range(99) < 20);
    end

    always @(posedge aclk) begin : result_check
        prime_tally_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tallies.size() == 0) begin
                $error("unexpected result transaction: prime_count %0d prime_sum %0d",
                       m_prime_count, m_prime_sum);
                error_count++;
            end else begin
                want = pending_tallies.pop_front();
                if (m_prime_count !== want.count) begin
                    $error("prime_count: expected %0d, actual %0d", want.count, m_prime_count);
                    error_count++;
                end
                if (m_prime_sum !== want.sum) begin
                    $error("prime_sum: expected %0d, actual %0d", want.sum, m_prime_sum);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("prime_range_count_sum_core_test failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned  i;
        int unsigned  mix;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  span;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_ROWS; i++) begin
            send_bounds(DIRECTED_ROWS[i].lo, DIRECTED_ROWS[i].hi,
                        DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].tally);
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            // quiet stretch with both sides always ready
            idle_on <= !(i >= 30 && i < 70);
            mix = $urandom_range(99);
            if (mix < 10) begin
                // empty range
                lo = $urandom_range(65535, 1);
                hi = $urandom_range(lo - 1, 0);
            end else if (mix < 20) begin
                // lower bound raised to 2
                lo = $urandom_range(1, 0);
                hi = $urandom_range(127, 0);
            end else if (mix < 60) begin
                hi = $urandom_range(1023, 0);
                span = (hi < 48) ? hi : 48;
                lo = hi - $urandom_range(span, 0);
            end else begin
                // narrow window anywhere in the bound space
                lo = $urandom_range(65535, 0);
                hi = lo + $urandom_range(6, 0);
                if (hi > 65535) begin
                    hi = 65535;
                end
            end
            send_bounds(lo[BOUND_W-1:0], hi[BOUND_W-1:0], 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_tallies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("prime_range_count_sum_core_test passed");
        end else begin
            $display("prime_range_count_sum_core_test failed");
        end
        $finish;
    end

endmodule

// File: prime_range_count_sum_core.f
rtl/core/prc_pkg.sv
rtl/core/prime_range_count_sum_core.sv
rtl/core/prc_checker.sv
sim/prime_range_count_sum_core_test.sv
